>>> hw/rtl/bls_pkg.sv
// Shared constants and types for the Bresenham line stepper.
`default_nettype none
package bls_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SCREEN_BITS    = 15;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 15'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 15'd768;

  // Configuration register indexes.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Input action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } bls_qstat_t;

endpackage
`default_nettype wire

>>> hw/rtl/bls_front.sv
// Input stage: takes beats, orders the endpoints and builds queue entries.
`default_nettype none
module bls_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire bls_pkg::bls_qstat_t          qstat,
  output logic                              push,
  output logic [4*COORD_BITS+4:0]           push_data
);
  import bls_pkg::*;

  localparam int W = COORD_BITS;

  logic         f_valid;
  logic         f_action;
  logic [W-1:0] f_ax, f_ay, f_bx, f_by;
  logic [W:0]   f_dx, f_dy;
  logic         f_load;

  logic [W:0]   adx, ady;
  logic         steep;
  logic [W:0]   maj_diff, min_diff;
  logic         swap;
  logic [W-1:0] a_maj, a_min, b_maj, b_min;
  logic [W-1:0] maj_start, min_start;
  logic         min_neg;

  assign in_stall = f_valid && qstat.full;
  assign f_load   = in_valid && !in_stall;
  assign push     = f_valid && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_load) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f_action <= action;
      f_ax     <= start_x;
      f_ay     <= start_y;
      f_bx     <= end_x;
      f_by     <= end_y;
      f_dx     <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
      f_dy     <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
    end
  end

  always_comb begin
    adx      = f_dx[W] ? (~f_dx + 1'b1) : f_dx;
    ady      = f_dy[W] ? (~f_dy + 1'b1) : f_dy;
    steep    = !(ady < adx);
    a_maj    = steep ? f_ay : f_ax;
    a_min    = steep ? f_ax : f_ay;
    b_maj    = steep ? f_by : f_bx;
    b_min    = steep ? f_bx : f_by;
    maj_diff = steep ? f_dy : f_dx;
    min_diff = steep ? f_dx : f_dy;
    // A negative major difference means the endpoints trade places,
    // which also flips the direction of the minor axis.
    swap      = maj_diff[W];
    maj_start = swap ? b_maj : a_maj;
    min_start = swap ? b_min : a_min;
    min_neg   = swap ? (!min_diff[W] && (min_diff != '0)) : min_diff[W];
  end

  assign push_data = {(f_action == ACT_LOAD), steep, min_neg, maj_start, min_start,
                      (steep ? ady : adx), (steep ? adx : ady)};

endmodule
`default_nettype wire

>>> hw/rtl/bls_queue.sv
// Short first-in first-out queue between the front and back parts.
`default_nettype none
module bls_queue #(
  parameter int DATA_BITS = 69,
  parameter int DEPTH     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] push_data,
  input  wire logic                 pop,
  output logic [DATA_BITS-1:0]      head,
  output bls_pkg::bls_qstat_t       qstat
);
  import bls_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]  count;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] r;
    r = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign qstat.full  = (count == CNT_BITS'(DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bls_back.sv
// Stepper: holds the line state, walks one pixel per step beat and drives the result register.
`default_nettype none
module bls_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [bls_pkg::SCREEN_BITS-1:0]   cfg_data,
  input  wire logic [4*COORD_BITS+4:0]           head,
  input  wire bls_pkg::bls_qstat_t               qstat,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [COORD_BITS-1:0]           pixel_x,
  output logic signed [COORD_BITS-1:0]           pixel_y,
  output logic                                   on_screen,
  output logic                                   pixel_valid,
  output logic                                   last_pixel
);
  import bls_pkg::*;

  localparam int W   = COORD_BITS;

  logic [SCREEN_BITS-1:0] screen_width, screen_height;

  // Queue entry fields.
  logic         h_load, h_steep, h_min_neg;
  logic [W-1:0] h_maj_start, h_min_start;
  logic [W:0]   h_maj_delta, h_min_delta;

  // Line state.
  logic           line_active, steep_mode, minor_negative;
  logic [W-1:0]   major_pos, minor_pos;
  logic [W:0]     remain;
  logic [W+1:0]   inc_flat;
  logic [W+2:0]   inc_diag;
  logic [W+2:0]   decision_term;

  logic           out_ready;
  logic           take_step;
  logic [W-1:0]   px, py;
  logic           px_ok, py_ok;

  assign {h_load, h_steep, h_min_neg, h_maj_start, h_min_start, h_maj_delta, h_min_delta} = head;

  assign out_ready = !out_valid || !out_stall;
  assign pop       = !qstat.empty && (h_load || out_ready);
  assign take_step = pop && !h_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    px    = steep_mode ? minor_pos : major_pos;
    py    = steep_mode ? major_pos : minor_pos;
    px_ok = !px[W-1] && ({SCREEN_BITS'(0), px} < {W'(0), screen_width});
    py_ok = !py[W-1] && ({SCREEN_BITS'(0), py} < {W'(0), screen_height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (pop && h_load) begin
      line_active <= (h_maj_delta != '0);
    end else if (take_step && line_active) begin
      line_active <= (remain != (W+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (pop && h_load) begin
      steep_mode     <= h_steep;
      minor_negative <= h_min_neg;
      major_pos      <= h_maj_start;
      minor_pos      <= h_min_start;
      remain         <= h_maj_delta;
      inc_flat       <= {h_min_delta, 1'b0};
      inc_diag       <= {1'b0, h_min_delta, 1'b0} - {1'b0, h_maj_delta, 1'b0};
      decision_term  <= {1'b0, h_min_delta, 1'b0} - {2'b00, h_maj_delta};
    end else if (take_step && line_active) begin
      major_pos <= major_pos + 1'b1;
      remain    <= remain - 1'b1;
      if (decision_term[W+2]) begin
        decision_term <= decision_term + {1'b0, inc_flat};
      end else begin
        decision_term <= decision_term + inc_diag;
        minor_pos     <= minor_negative ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // A step on a finished or empty line still returns a beat, all zero.
  always_ff @(posedge clk) begin
    if (take_step) begin
      if (line_active) begin
        pixel_x     <= px;
        pixel_y     <= py;
        on_screen   <= px_ok && py_ok;
        pixel_valid <= 1'b1;
        last_pixel  <= (remain == (W+1)'(1));
      end else begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        on_screen   <= 1'b0;
        pixel_valid <= 1'b0;
        last_pixel  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    action, start_x, start_y, end_x, end_y
//   out      output     out_valid/out_stall  pixel_x, pixel_y, on_screen, pixel_valid,
//                                            last_pixel
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One beat per clock in each direction unless stalled. A beat passes through the
// input register and then the four-entry queue before the stepper takes it; a
// step result appears in the output register the cycle after that.
// One error-term add per unstalled cycle sets the stepper's pixel rate.
// Reset is synchronous and empties the queue and output register; screen size
// returns to 1024 by 768. An output stall holds the result and backs up the
// queue; the input stalls only while the queue is full.
`default_nettype none
module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      pixel_x,
  output logic signed [COORD_BITS-1:0]      pixel_y,
  output logic                              on_screen,
  output logic                              pixel_valid,
  output logic                              last_pixel,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bls_pkg::SCREEN_BITS-1:0] cfg_data
);
  import bls_pkg::*;

  localparam int ENTRY_BITS = 4 * COORD_BITS + 5;

  logic                  push, pop;
  logic [ENTRY_BITS-1:0] push_data, head;
  bls_qstat_t            qstat;

  bls_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  bls_queue #(.DATA_BITS(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  bls_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .on_screen   (on_screen),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel)
  );

endmodule
`default_nettype wire

>>> hw/rtl/bls_checker.sv
// Port-level checks for the line stepper, bound to the top level.
`default_nettype none
module bls_checker #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         action,
  input wire logic signed [COORD_BITS-1:0] start_x,
  input wire logic signed [COORD_BITS-1:0] start_y,
  input wire logic signed [COORD_BITS-1:0] end_x,
  input wire logic signed [COORD_BITS-1:0] end_y,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic signed [COORD_BITS-1:0] pixel_x,
  input wire logic signed [COORD_BITS-1:0] pixel_y,
  input wire logic                         on_screen,
  input wire logic                         pixel_valid,
  input wire logic                         last_pixel
);

  // A stalled input beat keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(action) && $stable(start_x) &&
      $stable(start_y) && $stable(end_x) && $stable(end_y))
    else $error("input beat changed while stalled");

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(on_screen) && $stable(pixel_valid) && $stable(last_pixel))
    else $error("result beat changed while stalled");

  // A beat for a finished line carries nothing but zeros.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && !on_screen && !last_pixel)
    else $error("finished-line beat has nonzero fields");

  // An on-screen pixel is a real pixel with nonnegative coordinates.
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && on_screen |-> pixel_valid && !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
    else $error("on-screen flag on an invalid or negative pixel");

  // Reset leaves no result beat pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind bresenham_line_stepper bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the Bresenham line stepper: directed lines, screen sizes, random lines.
`default_nettype none
module tb_top;
  import bls_pkg::*;

  typedef struct {
    logic               act;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } line_cmd_t;

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               on_scr;
    logic               valid;
    logic               last_px;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_LOAD;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic on_screen;
  logic pixel_valid;
  logic last_pixel;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_SCREEN_WIDTH;
  logic [SCREEN_BITS-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  bresenham_line_stepper dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .on_screen(on_screen),
    .pixel_valid(pixel_valid), .last_pixel(last_pixel),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted line state and screen size.
  logic [SCREEN_BITS-1:0] scr_w = SCREEN_WIDTH_RST;
  logic [SCREEN_BITS-1:0] scr_h = SCREEN_HEIGHT_RST;
  logic               ln_active = 1'b0;
  logic               ln_steep = 1'b0;
  logic               ln_minor_neg = 1'b0;
  logic signed [15:0] ln_major = '0;
  logic signed [15:0] ln_minor = '0;
  logic signed [15:0] ln_major_end = '0;
  logic [16:0]        ln_major_d = '0;
  logic [16:0]        ln_minor_d = '0;
  logic signed [18:0] ln_err = '0;

  pixel_t pending_pixels[$];

  int mismatches = 0;
  int beats_sent = 0;
  int loads_sent = 0;
  int cfg_writes = 0;
  int pixels_seen = 0;
  int blanks_seen = 0;
  int onscreen_seen = 0;
  int lasts_seen = 0;

  int rx_mode = 0;
  bit tx_gappy = 1'b0;
  int burst_left = 0;

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Advances the predicted line by one beat and queues the pixel a step produces.
  task automatic trace_beat(input line_cmd_t c);
    int ax, ay, bx, by, amaj, amin, bmaj, bmin, t, px, py, e, m, mj;
    pixel_t p;
    if (c.act == ACT_LOAD) begin
      ax = int'(c.sx); ay = int'(c.sy); bx = int'(c.ex); by = int'(c.ey);
      ln_steep = !(iabs(by - ay) < iabs(bx - ax));
      if (ln_steep) begin
        amaj = ay; amin = ax; bmaj = by; bmin = bx;
      end else begin
        amaj = ax; amin = ay; bmaj = bx; bmin = by;
      end
      if (amaj > bmaj) begin
        t = amaj; amaj = bmaj; bmaj = t;
        t = amin; amin = bmin; bmin = t;
      end
      ln_major = 16'(amaj);
      ln_minor = 16'(amin);
      ln_major_end = 16'(bmaj);
      ln_major_d = 17'(bmaj - amaj);
      ln_minor_neg = (bmin - amin) < 0;
      ln_minor_d = 17'(iabs(bmin - amin));
      ln_err = 19'(2 * iabs(bmin - amin) - (bmaj - amaj));
      ln_active = amaj < bmaj;
      loads_sent++;
      return;
    end
    p = '{px: '0, py: '0, on_scr: 1'b0, valid: 1'b0, last_px: 1'b0};
    if (ln_active) begin
      px = ln_steep ? int'(ln_minor) : int'(ln_major);
      py = ln_steep ? int'(ln_major) : int'(ln_minor);
      p.px = 16'(px);
      p.py = 16'(py);
      p.on_scr = px >= 0 && py >= 0 && px < int'(scr_w) && py < int'(scr_h);
      p.valid = 1'b1;
      p.last_px = (int'(ln_major) + 1) == int'(ln_major_end);
      m = int'(ln_minor_d);
      mj = int'(ln_major_d);
      e = int'(ln_err);
      ln_major = ln_major + 16'sd1;
      if (e < 0) begin
        e = e + 2 * m;
      end else begin
        e = e + 2 * m - 2 * mj;
        ln_minor = ln_minor_neg ? ln_minor - 16'sd1 : ln_minor + 16'sd1;
      end
      ln_err = 19'(e);
      ln_active = ln_major < ln_major_end;
    end
    pending_pixels.push_back(p);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_beat(input line_cmd_t c);
    int gap;
    gap = 0;
    if (tx_gappy) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 8);
      end
      burst_left--;
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action <= c.act;
    start_x <= c.sx;
    start_y <= c.sy;
    end_x <= c.ex;
    end_y <= c.ey;
    do @(posedge clk); while (in_stall);
    trace_beat(c);
    beats_sent++;
  endtask

  // Endpoint fields of a step beat are ignored, so they carry noise.
  function automatic line_cmd_t step_cmd();
    line_cmd_t c;
    c.act = ACT_STEP;
    c.sx = 16'($urandom); c.sy = 16'($urandom); c.ex = 16'($urandom); c.ey = 16'($urandom);
    return c;
  endfunction

  function automatic line_cmd_t load_cmd(input int sx, input int sy, input int ex,
                                         input int ey);
    line_cmd_t c;
    c.act = ACT_LOAD;
    c.sx = 16'(sx); c.sy = 16'(sy); c.ex = 16'(ex); c.ey = 16'(ey);
    return c;
  endfunction

  task automatic steps(input int n);
    repeat (n) send_beat(step_cmd());
  endtask

  // Drains the block; loads leave no result, so a wait after the last pending result covers one in flight.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SCREEN_BITS'(value);
    @(posedge clk);
    if (idx == REG_SCREEN_WIDTH) scr_w = SCREEN_BITS'(value);
    else scr_h = SCREEN_BITS'(value);
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_screen(input int w, input int h);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  // One load followed by steps: a random count for a full-range line, else its length plus extra.
  task automatic send_line(input int span, input bit full_range, input int extra);
    line_cmd_t c;
    int len, n, dx, dy;
    if (full_range) begin
      c = load_cmd($urandom, $urandom, $urandom, $urandom);
    end else begin
      c.act = ACT_LOAD;
      c.sx = 16'(int'($urandom_range(0, int'(scr_w) + 16)) - 8);
      c.sy = 16'(int'($urandom_range(0, int'(scr_h) + 16)) - 8);
      c.ex = 16'(int'(c.sx) + int'($urandom_range(0, 2 * span)) - span);
      c.ey = 16'(int'(c.sy) + int'($urandom_range(0, 2 * span)) - span);
    end
    send_beat(c);
    dx = iabs(int'(c.ex) - int'(c.sx));
    dy = iabs(int'(c.ey) - int'(c.sy));
    len = (dx > dy) ? dx : dy;
    n = full_range ? int'($urandom_range(1, 24)) : len + extra;
    if (n > 0) steps(n);
  endtask

  task automatic test_directed();
    tx_gappy = 1'b0;
    rx_mode = 0;
    steps(1);
    send_line(0, 1'b0, 0);
    send_beat(load_cmd(0, 0, 3, 1));
    steps(4);
    send_beat(load_cmd(5, 5, 5, 5));
    steps(1);
    // Steep line given with the far end first, running into negative rows.
    send_beat(load_cmd(2, 3, 0, -1));
    steps(3);
    send_beat(load_cmd(-32768, -32768, 32767, 32767));
    steps(2);
    send_beat(load_cmd(32767, 0, -32768, 5));
    steps(1);
    send_beat(load_cmd(1023, 767, 1025, 760));
    steps(2);
    // Reload while the previous line is still active.
    send_beat(load_cmd(0, 0, 0, 2));
    steps(3);
  endtask

  task automatic test_screen_sizes();
    int sizes[5][2];
    sizes = '{'{0, 768}, '{1, 1}, '{32767, 32767}, '{1024, 0}, '{17, 9}};
    tx_gappy = 1'b1;
    rx_mode = 1;
    foreach (sizes[i]) begin
      set_screen(sizes[i][0], sizes[i][1]);
      repeat (6) send_line(12, 1'b0, int'($urandom_range(0, 2)));
    end
  endtask

  task automatic test_random_lines();
    int phase_start, r;
    line_cmd_t c;
    for (int phase = 0; phase < 4; phase++) begin
      set_screen(int'($urandom_range(1, 64)), int'($urandom_range(1, 64)));
      tx_gappy = (phase != 0);
      rx_mode = phase;
      phase_start = beats_sent;
      while (beats_sent - phase_start < 200) begin
        r = int'($urandom_range(0, 99));
        if (r < 8) begin
          c = step_cmd();
          c.act = 1'($urandom_range(0, 1));
          send_beat(c);
        end else if (r < 14) begin
          send_line(0, 1'b1, 0);
        end else if (r < 70) begin
          send_line(8, 1'b0, int'($urandom_range(0, 4)) - 2);
        end else if (r < 95) begin
          send_line(40, 1'b0, int'($urandom_range(0, 4)) - 2);
        end else begin
          send_line(200, 1'b0, int'($urandom_range(0, 1)));
        end
      end
    end
    set_screen(int'(SCREEN_WIDTH_RST), int'(SCREEN_HEIGHT_RST));
    repeat (20) send_line(30, 1'b0, 1);
  endtask

  // Receiver stall patterns: none, random, periodic, long holds.
  int rx_cyc = 0;
  int rx_hold = 0;
  always @(negedge clk) begin
    logic s;
    rx_cyc++;
    case (rx_mode)
      1: s = ($urandom_range(0, 99) < 30);
      2: s = (rx_cyc % 7) < 3;
      3: begin
        if (rx_hold > 0) begin
          rx_hold--;
          s = 1'b1;
        end else if ($urandom_range(0, 99) < 10) begin
          rx_hold = int'($urandom_range(1, 12));
          s = 1'b1;
        end else begin
          s = 1'b0;
        end
      end
      default: s = 1'b0;
    endcase
    out_stall <= s;
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x !== want.px)
          report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_x, want.px));
        if (pixel_y !== want.py)
          report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_y, want.py));
        if (on_screen !== want.on_scr)
          report_mismatch($sformatf("on_screen got %b want %b at (%0d,%0d)",
                                    on_screen, want.on_scr, want.px, want.py));
        if (pixel_valid !== want.valid)
          report_mismatch($sformatf("pixel_valid got %b want %b", pixel_valid, want.valid));
        if (last_pixel !== want.last_px)
          report_mismatch($sformatf("last_pixel got %b want %b at (%0d,%0d)",
                                    last_pixel, want.last_px, want.px, want.py));
        if (want.valid) pixels_seen++;
        else blanks_seen++;
        if (want.on_scr) onscreen_seen++;
        if (want.last_px) lasts_seen++;
      end
    end
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still pending", pending_pixels.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_screen_sizes();
    test_random_lines();
    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d beats (%0d loads) and %0d register writes.",
             beats_sent, loads_sent, cfg_writes);
    $display("Checked %0d pixels (%0d on screen, %0d line ends) and %0d blank results.",
             pixels_seen, onscreen_seen, lasts_seen, blanks_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_front.sv
hw/rtl/bls_queue.sv
hw/rtl/bls_back.sv
hw/rtl/bresenham_line_stepper.sv
hw/rtl/bls_checker.sv
tb/tb_top.sv
